// ----- rtl/prc_pkg.sv -----
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types, codes and CRC-32 helper for the packet reassembly checker.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int unsigned DEST_COUNT_DEFAULT = 256;
  localparam int unsigned CFG_INDEX_W        = 1;
  localparam int unsigned CFG_DATA_W         = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_CRC_CHECK = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SSI       = 1'b1;

  localparam logic [3:0]  HDR_VERSION  = 4'h2;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY_REV = 32'hEDB8_8320;
  localparam logic [3:0]  FULL_WORD    = 4'd8;

  typedef enum logic [2:0] {
    VERDICT_PENDING  = 3'd0,
    VERDICT_ACCEPT   = 3'd1,
    VERDICT_BAD_FMT  = 3'd2,
    VERDICT_SEQ_ERR  = 3'd3,
    VERDICT_CRC_ERR  = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [7:0]  first_user;
    logic [7:0]  dest;
    logic [15:0] count;
    logic        sof;
    logic        ver_ok;
  } header_t;

  typedef struct packed {
    logic        start;
    logic [15:0] count;
  } dest_entry_t;

  typedef struct packed {
    logic [63:0] payload_word;
    logic [3:0]  valid_bytes;
    logic        segment_end;
    verdict_t    verdict;
    logic [7:0]  dest_id;
    logic        frame_start;
    logic        frame_end;
    logic [7:0]  first_user;
    logic [7:0]  last_user;
    logic        ssi_error;
    logic [31:0] drop_total;
  } result_t;

  function automatic header_t unpack_header(input logic [63:0] d);
    header_t h;
    h.first_user = d[15:8];
    h.dest       = d[23:16];
    h.count      = d[47:32];
    h.sof        = d[63];
    h.ver_ok     = (d[3:0] == HDR_VERSION);
    return h;
  endfunction

  // Reflected CRC-32 over the low nbytes bytes of a word, byte 0 first.
  function automatic logic [31:0] crc_update(input logic [31:0] crc_in,
                                             input logic [63:0] data,
                                             input int unsigned nbytes);
    logic [31:0] c;
    c = crc_in;
    for (int unsigned i = 0; i < 8; i++) begin
      if (i < nbytes) begin
        c = c ^ {24'd0, data[8*i +: 8]};
        for (int b = 0; b < 8; b++) begin
          c = c[0] ? ((c >> 1) ^ CRC_POLY_REV) : (c >> 1);
        end
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/prc_dest_mem.sv -----
// ----------------------------------------------------------------------------
// prc_dest_mem
// Per-destination state: sequence entry and chained CRC, registered read.
// ----------------------------------------------------------------------------
module prc_dest_mem #(
  parameter int unsigned NUM_DEST = prc_pkg::DEST_COUNT_DEFAULT,
  parameter int unsigned AW       = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output prc_pkg::dest_entry_t  rd_entry,
  output logic [31:0]           rd_crc,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  prc_pkg::dest_entry_t  wr_entry,
  input  logic                  wr_crc_en,
  input  logic [31:0]           wr_crc
);
  import prc_pkg::*;

  dest_entry_t         entry_mem [NUM_DEST];
  logic [31:0]         crc_mem   [NUM_DEST];
  logic [NUM_DEST-1:0] written;
  dest_entry_t         entry_q;
  logic                written_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_entry;
    end
    if (wr_crc_en) begin
      crc_mem[wr_addr] <= wr_crc;
    end
    if (rd_en) begin
      entry_q <= entry_mem[rd_addr];
      rd_crc  <= crc_mem[rd_addr];
    end
  end

  // Written bits stand in for the reset value of the sequence entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        written_q <= written[rd_addr];
      end
    end
  end

  always_comb begin
    if (written_q) begin
      rd_entry = entry_q;
    end else begin
      rd_entry.start = 1'b1;
      rd_entry.count = '0;
    end
  end

endmodule

// ----- rtl/prc_out_reg.sv -----
// ----------------------------------------------------------------------------
// prc_out_reg
// Output request register; frees itself when the receiver takes the request.
// ----------------------------------------------------------------------------
module prc_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  prc_pkg::result_t load_data,
  input  logic             out_stall,
  output logic             out_valid,
  output prc_pkg::result_t out_data,
  output logic             busy
);
  import prc_pkg::*;

  assign busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

// ----- rtl/packet_reassembly_checker_core.sv -----
// ----------------------------------------------------------------------------
// packet_reassembly_checker_core
// Checks transport segments per destination and passes payload with verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries 64-bit beats: a header, one
//   or more payload words and a tail flagged by beat_last. Output channel
//   (out_valid / out_stall) carries one request per payload word but the
//   last, and a closing request on the tail with segment_end and verdict.
//   Payload words are held back: word n goes out when beat n+1 is taken,
//   the last with a tail that is not malformed. Each request appears in the
//   cycle after the beat that causes it is accepted. Throughput: one beat
//   per cycle while in_stall is low. The per-destination memory is read
//   once at the header and written once at the tail; one segment is in
//   flight at a time, so the two never touch the same entry together.
//   Stall: the output register holds the request; in_stall rises only while
//   a request waits there under out_stall, so no request is lost.
//   Reset: all destinations expect a start of frame with count zero, the
//   drop counter clears, CRC checking is on and SSI flagging is off. No
//   clearing pass is needed; the block accepts beats right after reset.
//   Configuration writes take effect at once and are meant for idle time.
// ----------------------------------------------------------------------------
module packet_reassembly_checker_core #(
  parameter int unsigned NUM_DEST = prc_pkg::DEST_COUNT_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [63:0]                      beat_data,
  input  logic                             beat_last,
  input  logic                             beat_error,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [63:0]                      payload_word,
  output logic [3:0]                       valid_bytes,
  output logic                             segment_end,
  output logic [2:0]                       verdict,
  output logic [7:0]                       dest_id,
  output logic                             frame_start,
  output logic                             frame_end,
  output logic [7:0]                       first_user,
  output logic [7:0]                       last_user,
  output logic                             ssi_error,
  output logic [31:0]                      drop_total,
  input  logic                             cfg_write,
  input  logic [prc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [prc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import prc_pkg::*;

  localparam int unsigned AW = (NUM_DEST > 1) ? $clog2(NUM_DEST) : 1;

  logic        crc_check_enable;
  logic        ssi_enable;
  logic [1:0]  beat_index;
  header_t     hdr;
  logic [63:0] held_word;
  logic [31:0] segment_crc;
  logic [31:0] drop_counter;

  logic        accept;
  logic        busy;
  header_t     cur_hdr;
  header_t     beat_hdr;
  logic        in_range;
  logic [AW-1:0] addr;
  dest_entry_t rd_entry;
  logic [31:0] rd_crc;
  logic [31:0] crc_base;
  logic [31:0] seg_crc_next;
  logic [31:0] final_crc;
  logic [31:0] tail_crc;
  logic        bad;
  logic        crc_err;
  logic        seq_err;
  logic        eof;
  logic [7:0]  luser;
  logic [7:0]  vb_raw;
  logic        mem_wr;
  dest_entry_t wr_entry;
  logic        res_valid;
  result_t     res;
  result_t     out_data;
  logic [31:0] drop_counter_next;

  assign accept   = in_valid && !in_stall;
  assign in_stall = busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_check_enable <= 1'b1;
      ssi_enable       <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CRC_CHECK: crc_check_enable <= cfg_data[0];
        CFG_SSI:       ssi_enable       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A tail with no header before it takes its own word as the header.
  assign beat_hdr = unpack_header(beat_data);
  assign cur_hdr  = (beat_index == 2'd0) ? beat_hdr : hdr;
  assign in_range = (32'(cur_hdr.dest) < NUM_DEST);
  assign addr     = cur_hdr.dest[AW-1:0];

  // Seed the segment CRC on the first payload beat, once the chained value
  // read at the header is back from memory.
  assign crc_base     = (hdr.sof || !in_range) ? CRC_INIT : ~rd_crc;
  assign seg_crc_next = (beat_index == 2'd1)
                        ? crc_update(crc_update(crc_base, held_word, 8), beat_data, 8)
                        : crc_update(segment_crc, beat_data, 8);
  assign final_crc    = ~crc_update(segment_crc, beat_data, 4);
  assign tail_crc     = {beat_data[39:32], beat_data[47:40],
                         beat_data[55:48], beat_data[63:56]};

  assign luser  = beat_data[7:0];
  assign eof    = beat_data[8];
  assign vb_raw = beat_data[23:16];

  assign bad     = beat_error || !cur_hdr.ver_ok || (beat_index != 2'd2) || !in_range;
  assign crc_err = crc_check_enable && (tail_crc != final_crc);
  assign seq_err = (rd_entry.start != hdr.sof) || (hdr.count != rd_entry.count) ||
                   (rd_entry.start && (rd_entry.count != '0));

  // Update the destination entry on every well-formed tail.
  assign mem_wr = accept && beat_last && !bad;
  always_comb begin
    if (crc_err || seq_err || eof) begin
      wr_entry.start = 1'b1;
      wr_entry.count = '0;
    end else begin
      wr_entry.start = 1'b0;
      wr_entry.count = rd_entry.count + 16'd1;
    end
  end

  prc_dest_mem #(
    .NUM_DEST (NUM_DEST),
    .AW       (AW)
  ) u_dest_mem (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept && !beat_last && (beat_index == 2'd0)),
    .rd_addr   (addr),
    .rd_entry  (rd_entry),
    .rd_crc    (rd_crc),
    .wr_en     (mem_wr),
    .wr_addr   (addr),
    .wr_entry  (wr_entry),
    .wr_crc_en (mem_wr && crc_check_enable),
    .wr_crc    (final_crc)
  );

  always_comb begin
    drop_counter_next = drop_counter;
    if (accept && beat_last && (bad || crc_err || seq_err)) begin
      drop_counter_next = drop_counter + 32'd1;
    end
  end

  // Build the request for this beat.
  assign res_valid = accept && (beat_last || (beat_index == 2'd2));
  always_comb begin
    res              = '0;
    res.dest_id      = cur_hdr.dest;
    res.drop_total   = drop_counter_next;
    res.verdict      = VERDICT_PENDING;
    if (!beat_last) begin
      res.payload_word = held_word;
      res.valid_bytes  = FULL_WORD;
    end else begin
      res.segment_end = 1'b1;
      if (bad) begin
        res.verdict = VERDICT_BAD_FMT;
      end else begin
        res.payload_word = held_word;
        res.valid_bytes  = (vb_raw > 8'd8) ? FULL_WORD : vb_raw[3:0];
        if (crc_err) begin
          res.verdict = VERDICT_CRC_ERR;
        end else if (seq_err) begin
          res.verdict = VERDICT_SEQ_ERR;
        end else begin
          res.verdict = VERDICT_ACCEPT;
          if (rd_entry.start) begin
            res.frame_start = 1'b1;
            res.first_user  = hdr.first_user;
          end
          if (eof) begin
            res.frame_end = 1'b1;
            res.last_user = luser;
            res.ssi_error = ssi_enable && luser[0];
          end
        end
      end
    end
  end

  // Segment tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_index   <= 2'd0;
      hdr          <= '0;
      held_word    <= '0;
      segment_crc  <= CRC_INIT;
      drop_counter <= '0;
    end else if (accept) begin
      drop_counter <= drop_counter_next;
      if (beat_last) begin
        beat_index <= 2'd0;
        if (beat_index == 2'd0) begin
          hdr <= beat_hdr;
        end
      end else if (beat_index == 2'd0) begin
        hdr        <= beat_hdr;
        held_word  <= beat_data;
        beat_index <= 2'd1;
      end else begin
        segment_crc <= seg_crc_next;
        held_word   <= beat_data;
        beat_index  <= 2'd2;
      end
    end
  end

  prc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .busy      (busy)
  );

  assign payload_word = out_data.payload_word;
  assign valid_bytes  = out_data.valid_bytes;
  assign segment_end  = out_data.segment_end;
  assign verdict      = out_data.verdict;
  assign dest_id      = out_data.dest_id;
  assign frame_start  = out_data.frame_start;
  assign frame_end    = out_data.frame_end;
  assign first_user   = out_data.first_user;
  assign last_user    = out_data.last_user;
  assign ssi_error    = out_data.ssi_error;
  assign drop_total   = out_data.drop_total;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid) else $error("input stalled with empty output register");

  a_tail_resets_index: assert property (@(posedge clk) disable iff (rst)
    (accept && beat_last) |=> (beat_index == 2'd0))
    else $error("beat index not cleared after tail");

  a_drop_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (drop_counter == $past(drop_counter)) ||
                    (drop_counter == $past(drop_counter) + 32'd1))
    else $error("drop counter jumped");

  a_request_follows_beat: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> out_valid) else $error("request lost");
`endif

endmodule

// ----- tb/packet_reassembly_checker_core_tb.sv -----
// ----------------------------------------------------------------------------
// packet_reassembly_checker_core_tb
// Self-checking bench for the packet reassembly checker. A cycle-free
// predictor tracks per-destination start/count/chained CRC and forecasts
// every request; a checker compares each delivered request in order.
// ----------------------------------------------------------------------------
module packet_reassembly_checker_core_tb;
  import prc_pkg::*;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        seg_end;
    verdict_t    verd;
    logic [7:0]  dest;
    logic        fstart;
    logic        fend;
    logic [7:0]  fuser;
    logic [7:0]  luser;
    logic        ssi;
    logic [31:0] drops;
  } seg_result_t;

  typedef enum int {FAULT_NONE, FAULT_VERSION, FAULT_ERRFLAG, FAULT_CRC} seg_fault_t;

  // DUT ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] beat_data = '0;
  logic        beat_last = 1'b0;
  logic        beat_error = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] payload_word;
  logic [3:0]  valid_bytes;
  logic        segment_end;
  logic [2:0]  verdict;
  logic [7:0]  dest_id;
  logic        frame_start;
  logic        frame_end;
  logic [7:0]  first_user;
  logic [7:0]  last_user;
  logic        ssi_error;
  logic [31:0] drop_total;
  logic        cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  packet_reassembly_checker_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a shadow of the block's registers and tables
  logic        crc_check_on;
  logic        ssi_on;
  logic        dest_expect_sof [256];
  logic [15:0] dest_expect_count [256];
  logic [31:0] dest_chain_crc [256];
  logic        dest_chain_valid [256];
  logic [1:0]  beat_pos;
  logic [63:0] header_word;
  logic [63:0] held_payload;
  logic [31:0] running_crc;
  logic [31:0] drops_seen;

  seg_result_t pending_results[$];
  int          mismatches = 0;
  int          results_checked = 0;
  int          beats_sent = 0;
  int          verdict_hits [5];

  // Sender pacing and receiver hold-off handshake
  int burst_left = 0;
  bit valid_dropped = 1'b0;
  int holdoff_requests = 0;
  int holdoff_served = 0;
  int holdoff_left = 0;

  // Reflected CRC-32, low bytes first
  function automatic logic [31:0] fold_crc(input logic [31:0] c, input logic [63:0] w,
                                           input int n);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < n; i++) begin
      r = r ^ {24'd0, w[8*i +: 8]};
      for (int b = 0; b < 8; b++) r = r[0] ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
    end
    return r;
  endfunction

  task automatic reset_shadow();
    crc_check_on = 1'b1;
    ssi_on = 1'b0;
    for (int i = 0; i < 256; i++) begin
      dest_expect_sof[i] = 1'b1;
      dest_expect_count[i] = '0;
      dest_chain_crc[i] = '0;
      dest_chain_valid[i] = 1'b0;
    end
    beat_pos = '0;
    header_word = '0;
    held_payload = '0;
    running_crc = '1;
    drops_seen = '0;
  endtask

  // Advance the shadow by one accepted beat and queue any request it causes
  task automatic predict_beat(input logic [63:0] d, input logic lst, input logic err);
    seg_result_t r;
    logic [7:0]  dst;
    logic        bad, crc_bad, seq_bad, was_sof;
    logic [31:0] tail_crc, calc_crc;
    r = '0;
    if (!lst) begin
      if (beat_pos == 0) begin
        header_word = d;
        dst = d[23:16];
        running_crc = d[63] ? 32'hFFFF_FFFF : (dest_chain_crc[dst] ^ 32'hFFFF_FFFF);
        running_crc = fold_crc(running_crc, d, 8);
        beat_pos = 1;
        return;
      end
      running_crc = fold_crc(running_crc, d, 8);
      if (beat_pos == 1) begin
        held_payload = d;
        beat_pos = 2;
        return;
      end
      r.word = held_payload;
      r.nbytes = 4'd8;
      r.verd = VERDICT_PENDING;
      r.dest = header_word[23:16];
      r.drops = drops_seen;
      held_payload = d;
      pending_results.push_back(r);
      return;
    end
    // tail beat
    if (beat_pos == 0) header_word = d;
    dst = header_word[23:16];
    bad = err || (header_word[3:0] != HDR_VERSION) || (beat_pos != 2);
    beat_pos = 0;
    r.seg_end = 1'b1;
    r.dest = dst;
    if (bad) begin
      drops_seen++;
      r.verd = VERDICT_BAD_FMT;
      r.drops = drops_seen;
      pending_results.push_back(r);
      verdict_hits[VERDICT_BAD_FMT]++;
      return;
    end
    tail_crc = {d[39:32], d[47:40], d[55:48], d[63:56]};
    calc_crc = fold_crc(running_crc, d, 4) ^ 32'hFFFF_FFFF;
    crc_bad = 1'b0;
    if (crc_check_on) begin
      dest_chain_crc[dst] = calc_crc;
      dest_chain_valid[dst] = 1'b1;
      crc_bad = (tail_crc != calc_crc);
    end
    was_sof = dest_expect_sof[dst];
    seq_bad = (was_sof != header_word[63]) || (header_word[47:32] != dest_expect_count[dst]) ||
              (was_sof && dest_expect_count[dst] != 0);
    r.word = held_payload;
    r.nbytes = (d[23:16] > 8) ? 4'd8 : d[19:16];
    if (crc_bad || seq_bad) begin
      drops_seen++;
      dest_expect_sof[dst] = 1'b1;
      dest_expect_count[dst] = '0;
      r.verd = crc_bad ? VERDICT_CRC_ERR : VERDICT_SEQ_ERR;
      r.drops = drops_seen;
      pending_results.push_back(r);
      verdict_hits[r.verd]++;
      return;
    end
    r.verd = VERDICT_ACCEPT;
    if (was_sof) begin
      dest_expect_sof[dst] = 1'b0;
      dest_expect_count[dst] = '0;
      r.fstart = 1'b1;
      r.fuser = header_word[15:8];
    end
    if (d[8]) begin
      dest_expect_sof[dst] = 1'b1;
      dest_expect_count[dst] = '0;
      r.fend = 1'b1;
      r.luser = d[7:0];
      r.ssi = ssi_on & d[0];
    end else begin
      dest_expect_count[dst] = dest_expect_count[dst] + 16'd1;
    end
    r.drops = drops_seen;
    pending_results.push_back(r);
    verdict_hits[VERDICT_ACCEPT]++;
  endtask

  // Offer one beat, hold it until taken, then maybe open a gap
  task automatic send_beat(input logic [63:0] d, input logic lst, input logic err);
    bit taken;
    int gap;
    in_valid <= 1'b1;
    beat_data <= d;
    beat_last <= lst;
    beat_error <= err;
    valid_dropped = 1'b0;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    predict_beat(d, lst, err);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        valid_dropped = 1'b1;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // Never let a non-SOF header read a chained CRC that was never stored
  function automatic logic [63:0] guard_header(input logic [63:0] h);
    logic [63:0] g;
    g = h;
    if (!dest_chain_valid[h[23:16]]) g[63] = 1'b1;
    return g;
  endfunction

  task automatic send_segment(input logic [7:0] dst, input logic sof, input logic [15:0] cnt,
                              input int npay, input logic eof, input logic [7:0] vb,
                              input seg_fault_t fault);
    logic [63:0] hdr, pay, tl;
    logic [31:0] c;
    hdr = {$urandom, $urandom};
    hdr[3:0] = (fault == FAULT_VERSION) ? (HDR_VERSION ^ 4'($urandom_range(1, 15)))
                                        : HDR_VERSION;
    hdr[23:16] = dst;
    hdr[47:32] = cnt;
    hdr[63] = sof;
    hdr = guard_header(hdr);
    c = hdr[63] ? 32'hFFFF_FFFF : (dest_chain_crc[dst] ^ 32'hFFFF_FFFF);
    c = fold_crc(c, hdr, 8);
    send_beat(hdr, 1'b0, 1'($urandom));
    for (int i = 0; i < npay; i++) begin
      pay = {$urandom, $urandom};
      c = fold_crc(c, pay, 8);
      send_beat(pay, 1'b0, 1'($urandom));
    end
    tl = {$urandom, $urandom};
    tl[8] = eof;
    tl[23:16] = vb;
    c = fold_crc(c, tl, 4) ^ 32'hFFFF_FFFF;
    if (fault == FAULT_CRC) c = c ^ (32'd1 << $urandom_range(31));
    tl[63:32] = {c[7:0], c[15:8], c[23:16], c[31:24]};
    send_beat(tl, 1'b1, fault == FAULT_ERRFLAG);
  endtask

  // Well-formed continuation of whatever frame the destination is in
  task automatic send_next(input logic [7:0] dst, input int npay, input logic eof,
                           input logic [7:0] vb);
    send_segment(dst, dest_expect_sof[dst], dest_expect_count[dst], npay, eof, vb, FAULT_NONE);
  endtask

  // Drain outstanding requests, then write a register
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic val);
    if (!valid_dropped) in_valid <= 1'b0;
    valid_dropped = 1'b1;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_CRC_CHECK) crc_check_on = val;
    else ssi_on = val;
  endtask

  function automatic logic [7:0] pick_dest();
    case ($urandom_range(9))
      0: return 8'hFF;
      1: return 8'($urandom);
      default: return 8'($urandom_range(3));
    endcase
  endfunction

  function automatic int pick_len();
    return ($urandom_range(30) == 0) ? $urandom_range(16, 24) : $urandom_range(1, 4);
  endfunction

  function automatic logic [7:0] pick_vb();
    return ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(8));
  endfunction

  // Receiver: own stall pattern, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holdoff_requests != holdoff_served) begin
      holdoff_served <= holdoff_requests;
      holdoff_left <= 80;
      out_stall <= 1'b1;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (($time / 2000) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3) == 0);
        2: out_stall <= ($urandom_range(3) != 0);
        default: out_stall <= (($time / 10) % 5) < 2;
      endcase
    end
  end

  // Check each delivered request against the oldest forecast
  always @(negedge clk) begin
    seg_result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {payload_word, valid_bytes, segment_end, verdict_t'(verdict), dest_id,
             frame_start, frame_end, first_user, last_user, ssi_error, drop_total};
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected request: %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected %h, got %h", $time, want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed_accepts();
    send_segment(8'd0, 1'b1, 16'd0, 1, 1'b1, 8'd8, FAULT_NONE);   // single-segment frame
    send_segment(8'hFF, 1'b1, 16'd0, 3, 1'b0, 8'd1, FAULT_NONE);  // frame opens on top dest
    send_next(8'hFF, 2, 1'b0, 8'd0);                              // chained continuation
    send_next(8'hFF, 1, 1'b1, 8'd15);                             // close, saturate byte count
    send_beat('1, 1'b0, 1'b1);                                    // all-ones header
    send_beat('0, 1'b0, 1'b0);
    send_beat('1, 1'b1, 1'b0);
  endtask

  task automatic test_directed_faults();
    send_segment(8'd1, 1'b1, 16'd0, 1, 1'b1, 8'd8, FAULT_VERSION);
    send_segment(8'd1, 1'b1, 16'd0, 1, 1'b1, 8'd8, FAULT_ERRFLAG);
    send_beat(64'h2, 1'b1, 1'b0);                                 // tail with no header
    send_segment(8'd1, 1'b1, 16'd0, 0, 1'b1, 8'd8, FAULT_NONE);   // header then tail
    send_segment(8'd1, 1'b1, 16'd5, 1, 1'b1, 8'd8, FAULT_NONE);   // count mismatch
    send_segment(8'd1, 1'b1, 16'd0, 1, 1'b0, 8'd4, FAULT_CRC);    // CRC mismatch
    send_segment(8'd1, 1'b1, 16'd0, 1, 1'b0, 8'd4, FAULT_NONE);
    send_segment(8'd1, 1'b1, 16'd1, 1, 1'b1, 8'd4, FAULT_NONE);   // SOF where none expected
  endtask

  task automatic test_registers();
    write_reg(CFG_SSI, 1'b1);
    send_segment(8'd2, 1'b1, 16'd0, 1, 1'b1, 8'd8, FAULT_NONE);
    write_reg(CFG_CRC_CHECK, 1'b0);
    send_segment(8'd2, 1'b1, 16'd0, 2, 1'b1, 8'd3, FAULT_CRC);    // CRC ignored
    write_reg(CFG_CRC_CHECK, 1'b1);
    write_reg(CFG_SSI, 1'b0);
  endtask

  task automatic test_backpressure();
    holdoff_requests++;
    for (int i = 0; i < 6; i++) send_next(8'd3, 3, 1'($urandom), 8'd8);
  endtask

  task automatic test_random_traffic();
    int r, n;
    logic [7:0] dst;
    while (beats_sent < 1350) begin
      if (beats_sent % 300 < 6 && beats_sent > 100) begin
        write_reg(CFG_CRC_CHECK, ($urandom_range(3) != 0));
        write_reg(CFG_SSI, 1'($urandom));
        if ($urandom_range(1)) holdoff_requests++;
      end
      r = $urandom_range(99);
      dst = pick_dest();
      if (r < 70) send_next(dst, pick_len(), ($urandom_range(2) == 0), pick_vb());
      else if (r < 76) send_segment(dst, 1'($urandom), 16'($urandom_range(2)), pick_len(),
                                    1'($urandom), pick_vb(), FAULT_NONE);
      else if (r < 82) send_segment(dst, dest_expect_sof[dst], dest_expect_count[dst],
                                    pick_len(), 1'($urandom), pick_vb(), FAULT_CRC);
      else if (r < 86) send_segment(dst, dest_expect_sof[dst], dest_expect_count[dst],
                                    pick_len(), 1'($urandom), pick_vb(), FAULT_VERSION);
      else if (r < 90) send_segment(dst, dest_expect_sof[dst], dest_expect_count[dst],
                                    pick_len(), 1'($urandom), pick_vb(), FAULT_ERRFLAG);
      else if (r < 94) send_segment(dst, dest_expect_sof[dst], dest_expect_count[dst],
                                    0, 1'($urandom), pick_vb(), FAULT_NONE);
      else begin
        // noise: random beats, headers kept away from unwritten chains, closed by a tail
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
          send_beat(beat_pos == 0 ? guard_header({$urandom, $urandom}) : {$urandom, $urandom},
                    1'b0, 1'($urandom));
        send_beat({$urandom, $urandom}, 1'b1, 1'($urandom));
      end
    end
  endtask

  initial begin
    reset_shadow();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_accepts();
    test_directed_faults();
    test_registers();
    test_backpressure();
    test_random_traffic();
    if (!valid_dropped) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d beats, %0d requests checked", beats_sent, results_checked);
    $display("verdicts: accept %0d, bad format %0d, sequence %0d, crc %0d",
             verdict_hits[VERDICT_ACCEPT], verdict_hits[VERDICT_BAD_FMT],
             verdict_hits[VERDICT_SEQ_ERR], verdict_hits[VERDICT_CRC_ERR]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/prc_pkg.sv
rtl/prc_dest_mem.sv
rtl/prc_out_reg.sv
rtl/packet_reassembly_checker_core.sv
tb/packet_reassembly_checker_core_tb.sv
